// ===== rtl/ltwq_pkg.sv =====
package ltwq_pkg;

    localparam int NUM_LOCKS_DEF   = 64;
    localparam int NUM_CLIENTS_DEF = 16;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RETRY = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic clearing;
        logic in_ready;
        logic exec;
    } t_ctrl;

endpackage

// ===== rtl/ltwq_ram.sv =====
module ltwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ltwq_fsm.sv =====
module ltwq_fsm
    import ltwq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_blocked,
    input  logic  i_clr_last,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_out_blocked) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctrl.clearing = 1'b1;
            end
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
            end
            S_READ: begin
                o_ctrl = '0;
            end
            S_EXEC: begin
                o_ctrl.exec = !i_out_blocked;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

// ===== rtl/ltwq_update.sv =====
module ltwq_update
    import ltwq_pkg::*;
#(
    parameter int NUM_CLIENTS = NUM_CLIENTS_DEF,
    localparam int CW   = $clog2(NUM_CLIENTS),
    localparam int CNTW = $clog2(NUM_CLIENTS + 1)
) (
    input  logic                   i_kind,
    input  logic                   i_in_range,
    input  logic [CW-1:0]          i_client,
    input  logic                   i_owner_valid,
    input  logic [CW-1:0]          i_owner_client,
    input  logic [NUM_CLIENTS-1:0] i_waiting,
    input  logic [CW-1:0]          i_head,
    input  logic [CNTW-1:0]        i_count,
    input  logic [CW-1:0]          i_fifo_rdata,
    output logic                   o_owner_valid,
    output logic [CW-1:0]          o_owner_client,
    output logic [NUM_CLIENTS-1:0] o_waiting,
    output logic [CW-1:0]          o_head,
    output logic [CNTW-1:0]        o_count,
    output logic                   o_tbl_we,
    output logic                   o_fifo_we,
    output logic [CW-1:0]          o_fifo_slot,
    output logic                   o_status,
    output logic                   o_waiters_flag,
    output logic                   o_notify_valid,
    output logic [CW-1:0]          o_notify_client,
    output logic                   o_notify_more
);

    localparam logic [CW:0]   NC_W   = (CW + 1)'(NUM_CLIENTS);
    localparam logic [CW-1:0] HD_MAX = CW'(NUM_CLIENTS - 1);

    logic [CW:0]     slot_sum;
    logic [CNTW-1:0] count_dec;
    logic            is_owner;
    logic            queue_empty;

    always_comb begin
        slot_sum = {1'b0, i_head} + (CW + 1)'(i_count);
        if (slot_sum >= NC_W) begin
            slot_sum = slot_sum - NC_W;
        end
        count_dec   = i_count - CNTW'(1);
        is_owner    = i_owner_valid && (i_owner_client == i_client);
        queue_empty = (i_count == '0);

        o_owner_valid   = i_owner_valid;
        o_owner_client  = i_owner_client;
        o_waiting       = i_waiting;
        o_head          = i_head;
        o_count         = i_count;
        o_tbl_we        = 1'b0;
        o_fifo_we       = 1'b0;
        o_fifo_slot     = slot_sum[CW-1:0];
        o_status        = STATUS_OK;
        o_waiters_flag  = 1'b0;
        o_notify_valid  = 1'b0;
        o_notify_client = '0;
        o_notify_more   = 1'b0;

        if (!i_in_range) begin
            o_status = (i_kind == KIND_ACQUIRE) ? STATUS_RETRY : STATUS_OK;
        end else if (i_kind == KIND_ACQUIRE) begin
            if (!i_owner_valid || (i_owner_client == i_client)) begin
                o_owner_valid  = 1'b1;
                o_owner_client = i_client;
                o_tbl_we       = 1'b1;
                o_waiters_flag = !queue_empty;
            end else begin
                o_status = STATUS_RETRY;
                if (queue_empty) begin
                    o_notify_valid  = 1'b1;
                    o_notify_client = i_owner_client;
                    o_notify_more   = 1'b1;
                end
                if (!i_waiting[i_client] && (i_count < CNTW'(NUM_CLIENTS))) begin
                    o_waiting[i_client] = 1'b1;
                    o_count             = i_count + CNTW'(1);
                    o_tbl_we            = 1'b1;
                    o_fifo_we           = 1'b1;
                end
            end
        end else if (is_owner) begin
            o_tbl_we = 1'b1;
            if (queue_empty) begin
                o_owner_valid  = 1'b0;
                o_owner_client = '0;
            end else begin
                o_waiting[i_fifo_rdata] = 1'b0;
                o_head          = (i_head == HD_MAX) ? '0 : i_head + CW'(1);
                o_count         = count_dec;
                o_owner_client  = i_fifo_rdata;
                o_notify_valid  = 1'b1;
                o_notify_client = i_fifo_rdata;
                o_notify_more   = (count_dec != '0);
            end
        end
    end

endmodule

// ===== rtl/lock_table_with_wait_queues.sv =====
// flow: an accepted item passes S_READ, then S_EXEC, where its result is registered; S_EXEC
//   holds while the o_ stage is stalled; no new item is taken until the item leaves S_EXEC, as the
//   lock table read is followed by the queue read whose address needs the queue head from that read
// reset: synchronous; afterwards a clearing pass zeroes each lock table entry in turn
//   while o_in_stall stays high; queue slots are not cleared
module lock_table_with_wait_queues
    import ltwq_pkg::*;
#(
    parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
    parameter int NUM_CLIENTS = NUM_CLIENTS_DEF,
    localparam int LW   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1,
    localparam int CW   = $clog2(NUM_CLIENTS),
    localparam int CNTW = $clog2(NUM_CLIENTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_kind,
    input  logic [LW-1:0] i_lock_id,
    input  logic [CW-1:0] i_client_id,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_status,
    output logic          o_waiters_flag,
    output logic          o_notify_valid,
    output logic [CW-1:0] o_notify_client,
    output logic          o_notify_more
);

    localparam int EW         = 1 + CW + NUM_CLIENTS + CW + CNTW;
    localparam int FIFO_DEPTH = 1 << (LW + CW);

    t_ctrl ctrl;

    logic [LW-1:0] r_clr_idx;
    logic          clr_last;
    logic          r_kind;
    logic [LW-1:0] r_lock;
    logic [CW-1:0] r_client;
    logic          in_accept;
    logic          out_blocked;
    logic          in_range;

    logic [LW-1:0] tbl_raddr;
    logic [LW-1:0] tbl_waddr;
    logic [EW-1:0] tbl_wdata;
    logic [EW-1:0] tbl_rdata;
    logic          tbl_we;

    logic                   ent_ov;
    logic [CW-1:0]          ent_oc;
    logic [NUM_CLIENTS-1:0] ent_wb;
    logic [CW-1:0]          ent_hd;
    logic [CNTW-1:0]        ent_ct;

    logic                   upd_ov;
    logic [CW-1:0]          upd_oc;
    logic [NUM_CLIENTS-1:0] upd_wb;
    logic [CW-1:0]          upd_hd;
    logic [CNTW-1:0]        upd_ct;
    logic                   upd_tbl_we;
    logic                   upd_fifo_we;
    logic [CW-1:0]          upd_slot;
    logic [CW-1:0]          fifo_rdata;

    logic          res_status;
    logic          res_waiters;
    logic          res_nv;
    logic [CW-1:0] res_nc;
    logic          res_nm;

    logic          r_out_valid;
    logic          r_status;
    logic          r_waiters_flag;
    logic          r_notify_valid;
    logic [CW-1:0] r_notify_client;
    logic          r_notify_more;

    assign out_blocked = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && ctrl.in_ready;
    assign o_in_stall  = !ctrl.in_ready;
    assign clr_last    = (r_clr_idx == LW'(NUM_LOCKS - 1));
    assign in_range    = ({1'b0, r_lock} < (LW + 1)'(NUM_LOCKS))
                      && ({1'b0, r_client} < (CW + 1)'(NUM_CLIENTS));

    ltwq_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_out_blocked (out_blocked),
        .i_clr_last    (clr_last),
        .o_ctrl        (ctrl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (ctrl.clearing) begin
            r_clr_idx <= r_clr_idx + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind   <= i_kind;
            r_lock   <= i_lock_id;
            r_client <= i_client_id;
        end
    end

    assign tbl_raddr = ctrl.in_ready ? i_lock_id : r_lock;
    assign tbl_waddr = ctrl.clearing ? r_clr_idx : r_lock;
    assign tbl_we    = ctrl.clearing || (ctrl.exec && upd_tbl_we);
    assign tbl_wdata = ctrl.clearing ? '0 : {upd_ov, upd_oc, upd_wb, upd_hd, upd_ct};
    assign {ent_ov, ent_oc, ent_wb, ent_hd, ent_ct} = tbl_rdata;

    ltwq_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_LOCKS)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    ltwq_ram #(
        .WIDTH (CW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_we    (ctrl.exec && upd_fifo_we),
        .i_waddr ({r_lock, upd_slot}),
        .i_wdata (r_client),
        .i_raddr ({r_lock, ent_hd}),
        .o_rdata (fifo_rdata)
    );

    ltwq_update #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_update (
        .i_kind          (r_kind),
        .i_in_range      (in_range),
        .i_client        (r_client),
        .i_owner_valid   (ent_ov),
        .i_owner_client  (ent_oc),
        .i_waiting       (ent_wb),
        .i_head          (ent_hd),
        .i_count         (ent_ct),
        .i_fifo_rdata    (fifo_rdata),
        .o_owner_valid   (upd_ov),
        .o_owner_client  (upd_oc),
        .o_waiting       (upd_wb),
        .o_head          (upd_hd),
        .o_count         (upd_ct),
        .o_tbl_we        (upd_tbl_we),
        .o_fifo_we       (upd_fifo_we),
        .o_fifo_slot     (upd_slot),
        .o_status        (res_status),
        .o_waiters_flag  (res_waiters),
        .o_notify_valid  (res_nv),
        .o_notify_client (res_nc),
        .o_notify_more   (res_nm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.exec) begin
            r_status        <= res_status;
            r_waiters_flag  <= res_waiters;
            r_notify_valid  <= res_nv;
            r_notify_client <= res_nc;
            r_notify_more   <= res_nm;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_waiters_flag  = r_waiters_flag;
    assign o_notify_valid  = r_notify_valid;
    assign o_notify_client = r_notify_client;
    assign o_notify_more   = r_notify_more;

    a_exec_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.exec |-> !(r_out_valid && i_out_stall))
        else $error("result written while output stage is held");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.clearing |-> o_in_stall)
        else $error("item accepted during clearing pass");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall ##1 o_in_stall)
        else $error("second item accepted before table update");

    a_fifo_with_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.exec && upd_fifo_we) |-> (tbl_we && !ctrl.clearing))
        else $error("queue slot written without table update");

endmodule
